// ===== rtl/core/pdr_pkg.sv =====
package pdr_pkg;

  localparam int StepBits   = 16;
  localparam int PeriodBits = 16;
  localparam int ScaledBits = StepBits + 3;
  localparam int ProdBits   = ScaledBits + PeriodBits;
  localparam int CntBits    = $clog2(ProdBits);

  localparam logic [PeriodBits-1:0] PeriodReset = PeriodBits'(1875);
  localparam logic [ScaledBits-1:0] StepInc     = ScaledBits'(5);

  typedef struct packed {
    logic                req_type;
    logic                ramp_down;
    logic [StepBits-1:0] step_count;
  } pdr_in_t;

  typedef struct packed {
    logic pwm_level;
    logic busy_res;
    logic ramp_last;
  } pdr_out_t;

  typedef struct packed {
    logic                  go;
    logic [ScaledBits-1:0] scaled;
    logic [ScaledBits-1:0] den;
    logic [PeriodBits-1:0] period;
  } md_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [PeriodBits-1:0] quot;
  } md_rsp_t;

endpackage

// ===== rtl/core/pdr_muldiv.sv =====
module pdr_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdr_pkg::md_req_t  req_i,
  output pdr_pkg::md_rsp_t  rsp_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  localparam int SW = pdr_pkg::ScaledBits;
  localparam int PW = pdr_pkg::PeriodBits;
  localparam int XW = pdr_pkg::ProdBits;
  localparam int CW = pdr_pkg::CntBits;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [XW:0]   mul_q, mul_d, mul_nx;
  logic [SW-1:0] rem_q, rem_d;
  logic [XW-1:0] dq_q, dq_d;
  logic [SW-1:0] scaled_q, scaled_d;
  logic [SW-1:0] den_q, den_d;
  logic [SW:0]   sum;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;

  // shift-add multiply, LSB of the period first
  assign sum    = mul_q[XW:PW] + (mul_q[0] ? {1'b0, scaled_q} : '0);
  assign mul_nx = {sum, mul_q[PW-1:0]} >> 1;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_q, dq_q[XW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    mul_d    = mul_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    scaled_d = scaled_q;
    den_d    = den_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.go) begin
          scaled_d = req_i.scaled;
          den_d    = req_i.den;
          mul_d    = {(SW + 1)'(0), req_i.period};
          cnt_d    = '0;
          state_d  = StMul;
        end
      end
      StMul: begin
        mul_d = mul_nx;
        if (cnt_q == CW'(PW - 1)) begin
          dq_d    = mul_nx[XW-1:0];
          rem_d   = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      StDiv: begin
        rem_d = ge ? diff[SW-1:0] : trial[SW-1:0];
        dq_d  = {dq_q[XW-2:0], ge};
        if (cnt_q == CW'(XW - 1)) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      StFin: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q    <= mul_d;
    rem_q    <= rem_d;
    dq_q     <= dq_d;
    scaled_q <= scaled_d;
    den_q    <= den_d;
  end

  assign rsp_o.busy = (state_q != StIdle);
  assign rsp_o.done = (state_q == StFin);
  assign rsp_o.quot = dq_q[PW-1:0];

endmodule

// ===== rtl/core/pwm_duty_ramp_generator.sv =====
// channel  direction  payload    handshake
// in       input      pdr_in_t   in_valid_i / in_stall_o
// out      output     pdr_out_t  out_valid_o / out_stall_i
// cfg      input      period     cfg_we_i (write only)
// A tick inside a period needs no divide; its result is registered.
// A start with a nonzero step count, or a tick that ends a period and goes
// on with the ramp, runs the serial multiply and divide with input stalled.
// Reset clears the ramp (idle) and loads a period of 1875 ticks.
// Input is stalled while a result is held by out_stall_i.
module pwm_duty_ramp_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pdr_pkg::pdr_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pdr_pkg::pdr_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pdr_pkg::PeriodBits-1:0]    cfg_wdata_i
);

  localparam int SW = pdr_pkg::ScaledBits;
  localparam int PW = pdr_pkg::PeriodBits;

  logic [PW-1:0]     period_q;
  logic [PW-1:0]     eff_p;
  logic [PW-1:0]     phase_q, phase_d;
  logic [SW-1:0]     scaled_q, scaled_d;
  logic [PW-1:0]     high_q, high_d;
  logic [SW-1:0]     tot5_q, tot5_d;
  logic [SW-1:0]     tot2p5_q, tot2p5_d;
  logic              running_q, running_d;
  logic              falling_q, falling_d;
  logic              out_valid_q, out_valid_d;
  pdr_pkg::pdr_out_t out_q, out_d;

  logic              in_acc;
  logic [SW-1:0]     n_ext, n5, n2;
  logic [SW-1:0]     scaled_inc, scaled_dec;
  logic              more_up, more_dn;
  logic              phase_end;
  pdr_pkg::md_req_t  md_req;
  pdr_pkg::md_rsp_t  md_rsp;

  pdr_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign in_stall_o = md_rsp.busy | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign eff_p      = (period_q == '0) ? PW'(1) : period_q;
  assign n_ext      = SW'(in_data_i.step_count);
  assign n5         = (n_ext << 2) + n_ext;
  assign n2         = n_ext << 1;
  assign scaled_inc = scaled_q + pdr_pkg::StepInc;
  assign scaled_dec = scaled_q - pdr_pkg::StepInc;
  assign more_up    = scaled_inc < tot5_q;
  assign more_dn    = scaled_q >= tot2p5_q;
  assign phase_end  = ({1'b0, phase_q} + (PW + 1)'(1)) >= {1'b0, eff_p};

  always_comb begin
    phase_d       = phase_q;
    scaled_d      = scaled_q;
    high_d        = md_rsp.done ? md_rsp.quot : high_q;
    tot5_d        = tot5_q;
    tot2p5_d      = tot2p5_q;
    running_d     = running_q;
    falling_d     = falling_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q & out_stall_i;
    md_req.go     = 1'b0;
    md_req.scaled = scaled_q;
    md_req.den    = tot5_q;
    md_req.period = eff_p;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (in_data_i.req_type) begin
        falling_d = in_data_i.ramp_down;
        tot5_d    = n5;
        tot2p5_d  = n2 + pdr_pkg::StepInc;
        phase_d   = '0;
        if (in_data_i.step_count == '0) begin
          running_d = 1'b0;
          scaled_d  = '0;
          high_d    = '0;
        end else begin
          running_d     = 1'b1;
          scaled_d      = in_data_i.ramp_down ? n5 : n2;
          md_req.go     = 1'b1;
          md_req.scaled = scaled_d;
          md_req.den    = n5;
        end
        out_d.busy_res = running_d;
      end else if (running_q) begin
        out_d.busy_res  = 1'b1;
        out_d.pwm_level = phase_q < high_q;
        if (phase_end) begin
          phase_d = '0;
          if (falling_q) begin
            if (more_dn) begin
              scaled_d = scaled_dec;
            end
          end else begin
            scaled_d = scaled_inc;
          end
          if (falling_q ? more_dn : more_up) begin
            md_req.go     = 1'b1;
            md_req.scaled = scaled_d;
          end else begin
            running_d       = 1'b0;
            out_d.ramp_last = 1'b1;
          end
        end else begin
          phase_d = phase_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= pdr_pkg::PeriodReset;
      phase_q     <= '0;
      scaled_q    <= '0;
      high_q      <= '0;
      tot5_q      <= '0;
      tot2p5_q    <= '0;
      running_q   <= 1'b0;
      falling_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      scaled_q    <= scaled_d;
      high_q      <= high_d;
      tot5_q      <= tot5_d;
      tot2p5_q    <= tot2p5_d;
      running_q   <= running_d;
      falling_q   <= falling_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_go_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.go |-> !md_rsp.busy)
    else $error("divider started while busy");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |=> !md_rsp.busy)
    else $error("divider still busy after done");

  a_running_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> tot5_q != '0)
    else $error("ramp running with zero length");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ramp_last |-> out_q.busy_res && !running_q)
    else $error("final tick inconsistent with ramp state");

endmodule
